// ===== rtl/core/tgst_pkg.sv =====
// ----------------------------------------------------------------------------
// tgst_pkg
// Shared types, codes and widths of the two-gate speed trap.
// ----------------------------------------------------------------------------
package tgst_pkg;

    localparam int TIME_W      = 48;
    localparam int REG_W       = 24;
    localparam int SPEED_W     = 38;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int SPEED_SCALE = 10000;
    localparam int DIV_STEPS   = SPEED_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 2;

    localparam int IN_FIELDS_W  = CMD_W + TIME_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + SPEED_W + TIME_W + REG_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [REG_W-1:0] SPACING_RST  = REG_W'(1000000);
    localparam logic [REG_W-1:0] MAX_DUR_RST  = REG_W'(10000000);
    localparam logic [REG_W-1:0] TIMEOUT_RST  = REG_W'(5000000);

    localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SECOND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ARM    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DISARM = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_NONE     = 3'd0,
        STAT_START    = 3'd1,
        STAT_SPEED    = 3'd2,
        STAT_BAD      = 3'd3,
        STAT_TIMEOUT  = 3'd4,
        STAT_ARMED    = 3'd5,
        STAT_DISARMED = 3'd6,
        STAT_IGNORED  = 3'd7
    } status_t;

    // one classified item on its way to the back end
    typedef struct packed {
        status_t              status;
        logic [TIME_W-1:0]    stamp;
        logic [REG_W-1:0]     elapsed;
        logic                 need_div;
        logic                 clr_speed;
    } job_t;

endpackage

// ===== rtl/core/two_gate_speed_trap.sv =====
// ----------------------------------------------------------------------------
// two_gate_speed_trap
// Two-beam speed trap: start capture, elapsed check and speed code.
//
//   channel   dir  handshake             payload
//   s_*       in   s_tvalid / s_tready   command, time_us
//   m_*       out  m_tvalid / m_tready   status, speed_code, start_stamp,
//                                        elapsed_out
//   cfg_*     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// a measurement runs in the back end as a dequeue, a multiply, 38 restoring
// divider steps and a result load; other commands skip the multiply and divide
// the front end classifies an item in the cycle it is accepted and hands it
// through a two-entry queue, so it stalls only when that queue is full
// the result register lets the back end divide while the output is stalled
// reset clears the capture, last speed, queue and output valid; config
// registers reset to their defaults
// ----------------------------------------------------------------------------
module two_gate_speed_trap
    import tgst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // command[2:0], time_us[50:3]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status[2:0], speed_code[40:3],
                                              // start_stamp[88:41],
                                              // elapsed_out[112:89]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [REG_W-1:0]       cfg_data
);

    logic [REG_W-1:0]    spacing_reg;
    logic [REG_W-1:0]    max_dur_reg;
    logic [REG_W-1:0]    timeout_reg;
    logic                push, pop, q_full, q_empty;
    job_t                push_job, pop_job;
    logic [STATUS_W-1:0] status;
    logic [SPEED_W-1:0]  speed_code;
    logic [TIME_W-1:0]   start_stamp;
    logic [REG_W-1:0]    elapsed_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RST;
            max_dur_reg <= MAX_DUR_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SPACING: spacing_reg <= cfg_data;
                REG_MAX_DUR: max_dur_reg <= cfg_data;
                REG_TIMEOUT: timeout_reg <= cfg_data;
                default:     spacing_reg <= spacing_reg;
            endcase
        end
    end

    tgst_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .command         (s_tdata[CMD_W-1:0]),
        .time_us         (s_tdata[CMD_W+TIME_W-1:CMD_W]),
        .max_duration_us (max_dur_reg),
        .timeout_us      (timeout_reg),
        .queue_full      (q_full),
        .push            (push),
        .push_job        (push_job)
    );

    tgst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    tgst_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .spacing_um  (spacing_reg),
        .queue_empty (q_empty),
        .queue_job   (pop_job),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .status      (status),
        .speed_code  (speed_code),
        .start_stamp (start_stamp),
        .elapsed_out (elapsed_out)
    );

    assign m_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                      elapsed_out, start_stamp, speed_code, status};

endmodule

// ===== rtl/core/tgst_front.sv =====
// ----------------------------------------------------------------------------
// tgst_front
// Accepts items, tracks the start capture and classifies each command.
// ----------------------------------------------------------------------------
module tgst_front
    import tgst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CMD_W-1:0]       command,
    input  logic [TIME_W-1:0]      time_us,
    input  logic [REG_W-1:0]       max_duration_us,
    input  logic [REG_W-1:0]       timeout_us,
    input  logic                   queue_full,
    output logic                   push,
    output job_t                   push_job
);

    logic [TIME_W-1:0] start_time_reg, start_time_next;
    logic              start_held_reg, start_held_next;
    logic [TIME_W-1:0] elapsed;
    logic              hi_zero;
    job_t              job;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign push_job = job;

    assign elapsed = time_us - start_time_reg;
    assign hi_zero = (elapsed[TIME_W-1:REG_W] == '0);

    always_comb
    begin
        job             = '0;
        job.status      = STAT_IGNORED;
        start_time_next = start_time_reg;
        start_held_next = start_held_reg;
        unique case (command)
            CMD_CHECK:
            begin
                job.status = STAT_NONE;
                // negative elapsed never times out
                if (start_held_reg && !elapsed[TIME_W-1] &&
                    (!hi_zero || (elapsed[REG_W-1:0] > timeout_us)))
                begin
                    job.status      = STAT_TIMEOUT;
                    job.stamp       = start_time_reg;
                    start_held_next = 1'b0;
                end
            end
            CMD_FIRST:
            begin
                if (!start_held_reg)
                begin
                    job.status      = STAT_START;
                    job.stamp       = time_us;
                    start_time_next = time_us;
                    start_held_next = 1'b1;
                end
            end
            CMD_SECOND:
            begin
                if (start_held_reg)
                begin
                    job.stamp       = start_time_reg;
                    job.elapsed     = hi_zero ? elapsed[REG_W-1:0] : '1;
                    start_held_next = 1'b0;
                    if (hi_zero && (elapsed[REG_W-1:0] != '0) &&
                        (elapsed[REG_W-1:0] < max_duration_us))
                    begin
                        job.status   = STAT_SPEED;
                        job.need_div = 1'b1;
                    end
                    else
                    begin
                        job.status = STAT_BAD;
                    end
                end
            end
            CMD_ARM:
            begin
                job.status      = STAT_ARMED;
                job.clr_speed   = 1'b1;
                start_held_next = 1'b0;
            end
            CMD_DISARM:
            begin
                job.status      = STAT_DISARMED;
                start_held_next = 1'b0;
            end
            default:
            begin
                job.status = STAT_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_held_reg <= 1'b0;
            start_time_reg <= '0;
        end
        else if (push)
        begin
            start_held_reg <= start_held_next;
            start_time_reg <= start_time_next;
        end
    end

endmodule

// ===== rtl/core/tgst_queue.sv =====
// ----------------------------------------------------------------------------
// tgst_queue
// Two-entry job queue between the front end and the divider back end.
// ----------------------------------------------------------------------------
module tgst_queue
    import tgst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/core/tgst_back.sv =====
// ----------------------------------------------------------------------------
// tgst_back
// Runs queued jobs: restoring divider for the speed code, keeps the last
// speed and holds the result register.
// ----------------------------------------------------------------------------
module tgst_back
    import tgst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [REG_W-1:0]       spacing_um,
    input  logic                   queue_empty,
    input  job_t                   queue_job,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [SPEED_W-1:0]     speed_code,
    output logic [TIME_W-1:0]      start_stamp,
    output logic [REG_W-1:0]       elapsed_out
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    job_t               job_reg, job_next;
    logic [SPEED_W-1:0] num_reg, num_next;
    logic [REG_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SPEED_W-1:0] last_speed_reg, last_speed_next;
    logic               out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [TIME_W-1:0]  stamp_reg, stamp_next;
    logic [REG_W-1:0]   elapsed_reg, elapsed_next;
    logic [REG_W:0]     trial;
    logic [REG_W:0]     diff;
    logic               q_bit;
    logic               out_free;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign speed_code  = speed_reg;
    assign start_stamp = stamp_reg;
    assign elapsed_out = elapsed_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == ST_IDLE) && !queue_empty;

    // one quotient bit per cycle, divisor is the elapsed time
    assign trial = {rem_reg, num_reg[SPEED_W-1]};
    assign diff  = trial - {1'b0, job_reg.elapsed};
    assign q_bit = !diff[REG_W];

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        last_speed_next = last_speed_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        speed_next      = speed_reg;
        stamp_next      = stamp_reg;
        elapsed_next    = elapsed_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    job_next   = queue_job;
                    state_next = queue_job.need_div ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                num_next   = SPEED_W'({{(SPEED_W-REG_W){1'b0}}, spacing_um} *
                                      SPEED_W'(SPEED_SCALE));
                rem_next   = '0;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = q_bit ? diff[REG_W-1:0] : trial[REG_W-1:0];
                num_next = {num_reg[SPEED_W-2:0], q_bit};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (job_reg.need_div)
                    begin
                        last_speed_next = num_reg;
                    end
                    else if (job_reg.clr_speed)
                    begin
                        last_speed_next = '0;
                    end
                    out_valid_next = 1'b1;
                    status_next    = job_reg.status;
                    speed_next     = job_reg.need_div ? num_reg :
                                     (job_reg.clr_speed ? '0 : last_speed_reg);
                    stamp_next     = job_reg.stamp;
                    elapsed_next   = job_reg.elapsed;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_speed_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_speed_reg <= last_speed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        status_reg  <= status_next;
        speed_reg   <= speed_next;
        stamp_reg   <= stamp_next;
        elapsed_reg <= elapsed_next;
    end

endmodule

// ===== rtl/core/tgst_checker.sv =====
// ----------------------------------------------------------------------------
// tgst_checker
// Port-level checks of the speed trap outputs.
// ----------------------------------------------------------------------------
module tgst_checker
    import tgst_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    logic [SPEED_W-1:0]  spd;
    logic [TIME_W-1:0]   stamp;
    logic [REG_W-1:0]    el;

    assign st    = m_tdata[STATUS_W-1:0];
    assign spd   = m_tdata[STATUS_W+SPEED_W-1:STATUS_W];
    assign stamp = m_tdata[STATUS_W+SPEED_W+TIME_W-1:STATUS_W+SPEED_W];
    assign el    = m_tdata[OUT_FIELDS_W-1:STATUS_W+SPEED_W+TIME_W];

    // a stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // a measured speed always comes with a nonzero elapsed time
    a_speed_el: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st == STAT_SPEED |-> el != '0)
        else $error("speed measured with zero elapsed");

    // arming clears the last speed
    a_arm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st == STAT_ARMED |-> spd == '0)
        else $error("speed not cleared on arm");

    // items without a capture carry no stamp and no elapsed time
    a_nostamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st == STAT_NONE || st == STAT_ARMED ||
                     st == STAT_DISARMED || st == STAT_IGNORED)
        |-> stamp == '0 && el == '0)
        else $error("stray stamp or elapsed time");

endmodule

bind two_gate_speed_trap tgst_checker u_tgst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
